>>> rtl/core/br2_pkg.sv
// ----------------------------------------------------------------------------
// br2_pkg
// Shared types, constants and the microcode table of the radix-2 Booth
// multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

package br2_pkg;

  // fixed port widths
  localparam int unsigned BR2_IN_W    = 32;
  localparam int unsigned BR2_OUT_W   = 64;
  // default operand width
  localparam int unsigned BR2_WIDTH   = 32;

  // microprogram addresses
  typedef enum logic [1:0] {
    S_FETCH = 2'd0,
    S_MUL   = 2'd1,
    S_WRITE = 2'd2
  } step_e;

  // jump conditions
  typedef enum logic [1:0] {
    C_IN_VALID = 2'd0,
    C_CNT_DONE = 2'd1,
    C_OUT_FREE = 2'd2
  } cond_e;

  // one control word
  typedef struct packed {
    logic  in_ready;
    logic  booth;
    logic  result_wr;
    cond_e cond;
    step_e jump;
    step_e next;
  } ucode_t;

  // datapath controls
  typedef struct packed {
    logic load;
    logic step;
  } br2_ctrl_t;

  // control store
  function automatic ucode_t br2_ucode(step_e addr);
    ucode_t w;
    w = '{in_ready: 1'b0, booth: 1'b0, result_wr: 1'b0,
          cond: C_IN_VALID, jump: S_FETCH, next: S_FETCH};
    case (addr)
      S_FETCH: begin
        w.in_ready = 1'b1;
        w.cond     = C_IN_VALID;
        w.jump     = S_MUL;
        w.next     = S_FETCH;
      end
      S_MUL: begin
        w.booth = 1'b1;
        w.cond  = C_CNT_DONE;
        w.jump  = S_WRITE;
        w.next  = S_MUL;
      end
      S_WRITE: begin
        w.result_wr = 1'b1;
        w.cond      = C_OUT_FREE;
        w.jump      = S_FETCH;
        w.next      = S_WRITE;
      end
      default: begin
        w.jump = S_FETCH;
        w.next = S_FETCH;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/br2_datapath.sv
// ----------------------------------------------------------------------------
// br2_datapath
// Booth accumulator, multiplier shift register and shared add/subtract unit.
// ----------------------------------------------------------------------------
`default_nettype none

module br2_datapath
  import br2_pkg::*;
#(
  parameter int unsigned WIDTH = BR2_WIDTH
) (
  input  wire logic                   clk_i,
  input  wire br2_ctrl_t              ctrl_i,
  input  wire logic [BR2_IN_W-1:0]    mcand_i,
  input  wire logic [BR2_IN_W-1:0]    mplier_i,
  output      logic [2*WIDTH-1:0]     prod_o
);

  // accumulator carries one guard bit so that a - (-2^(w-1)) never wraps
  logic [WIDTH:0]   acc_q, acc_d;
  logic [WIDTH:0]   mcand_q, mcand_d;
  logic [WIDTH-1:0] mq_q, mq_d;
  logic             qm1_q, qm1_d;
  logic [WIDTH:0]   sum;

  always_comb begin
    sum = acc_q;
    case ({mq_q[0], qm1_q})
      2'b01:   sum = acc_q + mcand_q;
      2'b10:   sum = acc_q - mcand_q;
      default: sum = acc_q;
    endcase
  end

  always_comb begin
    acc_d   = acc_q;
    mcand_d = mcand_q;
    mq_d    = mq_q;
    qm1_d   = qm1_q;
    if (ctrl_i.load) begin
      acc_d   = '0;
      mcand_d = {mcand_i[WIDTH-1], mcand_i[WIDTH-1:0]};
      mq_d    = mplier_i[WIDTH-1:0];
      qm1_d   = 1'b0;
    end else if (ctrl_i.step) begin
      // add or subtract, then arithmetic shift right of {acc, mq, qm1}
      acc_d = {sum[WIDTH], sum[WIDTH:1]};
      mq_d  = {sum[0], mq_q[WIDTH-1:1]};
      qm1_d = mq_q[0];
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    mcand_q <= mcand_d;
    mq_q    <= mq_d;
    qm1_q   <= qm1_d;
  end

  assign prod_o = {acc_q[WIDTH-1:0], mq_q};

endmodule

`default_nettype wire

>>> rtl/core/booth_radix2_multiplier.sv
// ----------------------------------------------------------------------------
// booth_radix2_multiplier
// Iterative radix-2 Booth signed multiplier run by a small microprogram.
// ----------------------------------------------------------------------------
// usage:
//   input channel: in_valid_i / in_ready_o with multiplicand_i, multiplier_i
//   (two's complement; only the low WIDTH bits are used, sign taken from
//   bit WIDTH-1). output channel: out_valid_o / out_ready_i with product_o,
//   the exact 2*WIDTH-bit product sign-extended to 64 bits.
//   a request is taken in the fetch step. the shared add/subtract unit then
//   does one Booth step per cycle, WIDTH Booth steps in all, and the write
//   step then moves the product to the output register. a new request is
//   taken only once the sequencer is back in the fetch step, after the WIDTH
//   Booth steps and the write step of the last request are done.
//   the output register lets the next request be taken and worked on while a
//   finished product still waits; if the receiver stalls longer, the write
//   step holds until the output register frees up.
//   reset (rst_ni low, asynchronous) puts the sequencer in the fetch step and
//   empties the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module booth_radix2_multiplier
  import br2_pkg::*;
#(
  parameter int unsigned WIDTH = BR2_WIDTH
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output      logic                 in_ready_o,
  input  wire logic [BR2_IN_W-1:0]  multiplicand_i,
  input  wire logic [BR2_IN_W-1:0]  multiplier_i,
  output      logic                 out_valid_o,
  input  wire logic                 out_ready_i,
  output      logic [BR2_OUT_W-1:0] product_o
);

  localparam int unsigned CNT_W = $clog2(WIDTH);

  // sequencer state
  step_e            step_q, step_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  ucode_t           uword;
  logic             cond_true;

  // output register
  logic                 out_valid_q, out_valid_d;
  logic [BR2_OUT_W-1:0] product_q, product_d;

  logic             in_accept;
  logic             out_free;
  br2_ctrl_t        ctrl;
  logic [2*WIDTH-1:0] prod;

  // fetch the control word of the current step
  assign uword      = br2_ucode(step_q);
  assign in_ready_o = uword.in_ready;
  assign in_accept  = in_valid_i & uword.in_ready;
  // output register can take a product this cycle
  assign out_free   = ~out_valid_q | out_ready_i;

  always_comb begin
    case (uword.cond)
      C_IN_VALID: cond_true = in_valid_i;
      C_CNT_DONE: cond_true = (cnt_q == '0);
      C_OUT_FREE: cond_true = out_free;
      default:    cond_true = 1'b0;
    endcase
  end

  // next step: conditional jump or stay/fall through
  always_comb begin
    step_d = cond_true ? uword.jump : uword.next;
    cnt_d  = cnt_q;
    if (in_accept) begin
      cnt_d = CNT_W'(WIDTH - 1);
    end else if (uword.booth) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= S_FETCH;
      cnt_q  <= '0;
    end else begin
      step_q <= step_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath controls
  assign ctrl.load = in_accept;
  assign ctrl.step = uword.booth;

  br2_datapath #(
    .WIDTH (WIDTH)
  ) u_datapath (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .mcand_i  (multiplicand_i),
    .mplier_i (multiplier_i),
    .prod_o   (prod)
  );

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    product_d   = product_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (uword.result_wr && out_free) begin
      out_valid_d = 1'b1;
      product_d   = BR2_OUT_W'($signed(prod));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    product_q <= product_d;
  end

  assign out_valid_o = out_valid_q;
  assign product_o   = product_q;

  // a taken request starts a full run of Booth steps
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (step_q == S_MUL) && (cnt_q == CNT_W'(WIDTH - 1)))
    else $error("request did not start a full Booth run");

  // the last Booth step hands over to the write step
  a_last_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == S_MUL) && (cnt_q == '0) |=> (step_q == S_WRITE))
    else $error("Booth loop overran its count");

  // a write step with a free output register yields a valid product
  a_write_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == S_WRITE) && out_free |=> out_valid_q && (step_q == S_FETCH))
    else $error("product not written on a free output register");

  // a product only appears out of the write step
  a_valid_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(step_q) == S_WRITE))
    else $error("output valid raised outside the write step");

endmodule

`default_nettype wire
